// ===== rtl/shared_page_refcount_table_macros.svh =====
// Assertion macros for the checker file sprt_chk.sv.
`ifndef SHARED_PAGE_REFCOUNT_TABLE_MACROS_SVH
`define SHARED_PAGE_REFCOUNT_TABLE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SPRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sprt_pkg.sv =====
// Package: constants, word types and codes of the shared page refcount table.
`timescale 1ns / 1ps

package sprt_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int SLOT_OUT_W  = 6;
    localparam int PAGE_BYTES  = 4096;
    localparam int KEY_W       = 32;
    localparam int FRAME_W     = 20;
    localparam int COUNT_W     = 16;
    localparam int SIZE_W      = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SIZE_W-1:0]  PAGE_MASK = SIZE_W'(PAGE_BYTES - 1);
    localparam logic [SIZE_W-1:0]  PAGE_SIZE = SIZE_W'(PAGE_BYTES);

    localparam logic MODE_OPEN  = 1'b0;
    localparam logic MODE_CLOSE = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_ALLOC    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BAD_ID   = 3'd3,
        ST_CLOSED   = 3'd4,
        ST_FREED    = 3'd5,
        ST_NOTFOUND = 3'd6
    } status_t;

    typedef struct packed {
        logic               mode;
        logic [KEY_W-1:0]   page_id;
        logic [FRAME_W-1:0] fresh_frame;
        logic [SIZE_W-1:0]  process_size;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [SIZE_W-1:0]     map_address;
        logic [FRAME_W-1:0]    frame_number;
        logic [SIZE_W-1:0]     new_process_size;
        logic [COUNT_W-1:0]    refcount_after;
        logic [SLOT_OUT_W-1:0] slot_index;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } stat_t;

    function automatic logic [SIZE_W-1:0] round_to_page(input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] sum;
        sum = sz + PAGE_MASK;
        return sum & ~PAGE_MASK;
    endfunction

    function automatic logic [SLOT_OUT_W-1:0] to_slot_out(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+SLOT_OUT_W-1:0] ext;
        ext = {{SLOT_OUT_W{1'b0}}, idx};
        return ext[SLOT_OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/sprt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/sprt_ctrl.sv =====
// Controller: sequences load, table scan, last compare and commit of one word.
`timescale 1ns / 1ps

module sprt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output sprt_pkg::cmd_t cmd,
    input  sprt_pkg::stat_t stat
);
    import sprt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FLUSH  = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            // read data of the last slot is compared here
            S_FLUSH:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/sprt_dp.sv =====
// Datapath: slot RAM, valid bits, scan compare, update and result register.
`timescale 1ns / 1ps

module sprt_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  sprt_pkg::cmd_t  cmd,
    input  sprt_pkg::req_t  req,
    output sprt_pkg::stat_t stat,
    output logic            done,
    output sprt_pkg::rsp_t  rsp
);
    import sprt_pkg::*;

    req_t                     req_reg;
    logic [SIZE_W-1:0]        map_reg;
    logic [SLOT_W-1:0]        scan_idx_reg;
    logic [SLOT_W-1:0]        cmp_idx_reg;
    logic                     cmp_vld_reg;
    logic                     hit_reg;
    logic [SLOT_W-1:0]        hit_idx_reg;
    logic [FRAME_W-1:0]       hit_frame_reg;
    logic [COUNT_W-1:0]       hit_count_reg;
    logic                     free_reg;
    logic [SLOT_W-1:0]        free_idx_reg;
    logic [TABLE_SLOTS-1:0]   valid_reg;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;
    logic                     done_reg;

    logic                     ram_we;
    logic [SLOT_W-1:0]        ram_waddr;
    entry_t                   ram_wentry;
    logic [ENTRY_W-1:0]       ram_rdata;
    entry_t                   rd_entry;

    logic                     match;
    logic                     free_hit;
    logic [COUNT_W-1:0]       count_up;
    logic [COUNT_W-1:0]       count_dn;
    logic [SIZE_W-1:0]        grown;
    logic                     valid_set;
    logic                     valid_clr;
    logic [SLOT_W-1:0]        valid_idx;

    sprt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (cmd.scan),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // a live slot never holds key 0, so a valid compare implies a real hit
    assign match    = cmp_vld_reg && valid_reg[cmp_idx_reg] && !hit_reg
                      && (rd_entry.key == req_reg.page_id);
    assign free_hit = cmd.scan && !valid_reg[scan_idx_reg] && !free_reg;

    assign stat.scan_last = (scan_idx_reg == SLOT_W'(TABLE_SLOTS - 1));

    assign count_up = (hit_count_reg == COUNT_MAX) ? COUNT_MAX : hit_count_reg + 1'b1;
    assign count_dn = (hit_count_reg != '0) ? hit_count_reg - 1'b1 : '0;
    assign grown    = map_reg + PAGE_SIZE;

    always_comb
    begin
        rsp_next         = '0;
        ram_we           = 1'b0;
        ram_waddr        = hit_idx_reg;
        ram_wentry.key   = req_reg.page_id;
        ram_wentry.frame = hit_frame_reg;
        ram_wentry.count = count_up;
        valid_set        = 1'b0;
        valid_clr        = 1'b0;
        valid_idx        = hit_idx_reg;
        if (req_reg.mode == MODE_OPEN)
        begin
            rsp_next.map_address      = map_reg;
            rsp_next.new_process_size = req_reg.process_size;
            if (req_reg.page_id == '0)
            begin
                rsp_next.status = ST_BAD_ID;
            end
            else if (hit_reg)
            begin
                rsp_next.status           = ST_HIT;
                rsp_next.frame_number     = hit_frame_reg;
                rsp_next.new_process_size = grown;
                rsp_next.refcount_after   = count_up;
                rsp_next.slot_index       = to_slot_out(hit_idx_reg);
                ram_we                    = cmd.commit;
            end
            else if (free_reg)
            begin
                rsp_next.status           = ST_ALLOC;
                rsp_next.frame_number     = req_reg.fresh_frame;
                rsp_next.new_process_size = grown;
                rsp_next.refcount_after   = COUNT_W'(1);
                rsp_next.slot_index       = to_slot_out(free_idx_reg);
                ram_we                    = cmd.commit;
                ram_waddr                 = free_idx_reg;
                ram_wentry.frame          = req_reg.fresh_frame;
                ram_wentry.count          = COUNT_W'(1);
                valid_set                 = cmd.commit;
                valid_idx                 = free_idx_reg;
            end
            else
            begin
                rsp_next.status = ST_FULL;
            end
        end
        else
        begin
            if (req_reg.page_id == '0)
            begin
                rsp_next.status = ST_BAD_ID;
            end
            else if (!hit_reg)
            begin
                rsp_next.status = ST_NOTFOUND;
            end
            else if (count_dn == '0)
            begin
                rsp_next.status       = ST_FREED;
                rsp_next.frame_number = hit_frame_reg;
                rsp_next.slot_index   = to_slot_out(hit_idx_reg);
                valid_clr             = cmd.commit;
            end
            else
            begin
                rsp_next.status         = ST_CLOSED;
                rsp_next.frame_number   = hit_frame_reg;
                rsp_next.refcount_after = count_dn;
                rsp_next.slot_index     = to_slot_out(hit_idx_reg);
                ram_we                  = cmd.commit;
                ram_wentry.count        = count_dn;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.scan;
            done_reg    <= cmd.commit;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                if (free_hit)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (valid_set)
            begin
                valid_reg[valid_idx] <= 1'b1;
            end
            if (valid_clr)
            begin
                valid_reg[valid_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx_reg;
        if (cmd.load)
        begin
            req_reg <= req;
            map_reg <= round_to_page(req.process_size);
        end
        if (match)
        begin
            hit_idx_reg   <= cmp_idx_reg;
            hit_frame_reg <= rd_entry.frame;
            hit_count_reg <= rd_entry.count;
        end
        if (free_hit)
        begin
            free_idx_reg <= scan_idx_reg;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== rtl/shared_page_refcount_table.sv =====
// Top level of the shared page refcount table.
//
// Usage: drive req and raise start; the word is taken at a clock edge with
// start high and busy low. req.mode selects open or close of req.page_id.
// The block then scans all TABLE_SLOTS slots of its slot RAM, one read per
// cycle, looking for the key and for the lowest free slot, then passes a
// flush state and commits the update in the commit state. One result word
// appears on rsp with done high for exactly one cycle. busy is low in that
// done cycle, so the next word can be accepted at the edge that ends it; a
// new word is not taken while one is in flight, as the slots are read one at
// a time through the single read port of the slot RAM.
// The receiver cannot stall: each result is valid only during its done
// cycle and must be captured then.
// Reset clears the valid bit of every slot at once, so the table reads as
// all empty right after reset; no clearing pass is needed.
`timescale 1ns / 1ps

module shared_page_refcount_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  sprt_pkg::req_t req,
    output logic           done,
    output sprt_pkg::rsp_t rsp
);
    import sprt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sprt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    sprt_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

// ===== rtl/sprt_chk.sv =====
// Port-level checker for the shared page refcount table, bound to the top level.
`timescale 1ns / 1ps
`include "shared_page_refcount_table_macros.svh"

module sprt_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input sprt_pkg::rsp_t rsp
);
    import sprt_pkg::*;

    logic open_rsp;
    logic open_ok;
    logic nf_rsp;
    logic nf_zero;

    assign open_rsp = done && (rsp.status == ST_HIT || rsp.status == ST_ALLOC);
    assign open_ok  = (rsp.refcount_after != '0)
                      && (rsp.new_process_size == rsp.map_address + PAGE_SIZE);
    assign nf_rsp   = done && (rsp.status == ST_NOTFOUND);
    assign nf_zero  = (rsp.map_address == '0) && (rsp.frame_number == '0)
                      && (rsp.refcount_after == '0) && (rsp.slot_index == '0);

    `SPRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `SPRT_ASSERT_NEXT(a_done_single, done, !done, "done strobe longer than one cycle")
    `SPRT_ASSERT_SAME(a_open_ok, open_rsp, open_ok, "successful open with bad count or size")
    `SPRT_ASSERT_SAME(a_notfound_zero, nf_rsp, nf_zero, "not-found close with nonzero fields")

endmodule

bind shared_page_refcount_table sprt_chk u_chk (.*);
